>>> src/idq_pkg.sv
`timescale 1ns / 1ps
// Package for the indexed deque buffer: default sizes, operation and status
// codes, and the word types of both channels. Depends on nothing.

package idq_pkg;

    localparam int DEPTH_DEFAULT     = 128;
    localparam int WORD_BITS_DEFAULT = 32;

    // Operation codes carried in the operation field.
    localparam logic [2:0] OP_PUSH_BACK   = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT  = 3'd1;
    localparam logic [2:0] OP_POP_BACK    = 3'd2;
    localparam logic [2:0] OP_POP_FRONT   = 3'd3;
    localparam logic [2:0] OP_READ_INDEX  = 3'd4;
    localparam logic [2:0] OP_WRITE_INDEX = 3'd5;

    // Status codes carried in the status field.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic        [2:0]  operation;
        logic signed [31:0] value;
        logic        [6:0]  index;
    } idq_in_t;

    typedef struct packed {
        logic signed [31:0] data;
        logic        [7:0]  count;
        logic        [1:0]  status;
    } idq_out_t;

    // What the control stage hands to the result stage for one word.
    typedef struct packed {
        logic       rd;
        logic [7:0] count;
        logic [1:0] status;
    } idq_meta_t;

endpackage

>>> src/idq_ram.sv
`timescale 1ns / 1ps
// Entry storage of the deque: one write port and one registered read port.
// Depends on nothing.

module idq_ram #(
    parameter int DEPTH     = 128,
    parameter int WORD_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic [WORD_BITS-1:0]         wdata,
    input  logic                         re,
    input  logic [$clog2(DEPTH)-1:0]     raddr,
    output logic [WORD_BITS-1:0]         rdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // The read data holds while no new read is issued.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/idq_ctrl.sv
`timescale 1ns / 1ps
// Head and count registers of the deque, and decoding of one operation into
// a memory access plus result information. Depends on idq_pkg.

module idq_ctrl #(
    parameter int DEPTH     = 128,
    parameter int WORD_BITS = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step,
    input  idq_pkg::idq_in_t          item,
    output logic                      mem_we,
    output logic                      mem_re,
    output logic [$clog2(DEPTH)-1:0]  mem_addr,
    output logic [WORD_BITS-1:0]      mem_wdata,
    output idq_pkg::idq_meta_t        meta
);
    import idq_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;

    logic [AW-1:0]   head_reg, head_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    logic            full, empty, idx_ok;
    logic [CMPW-1:0] idx_w, cnt_w;
    logic [CW-1:0]   offset;
    logic [AW-1:0]   slot, head_dec, head_inc;
    logic signed [63:0] value_ext;

    // Physical slot of head plus an offset below DEPTH.
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign full   = (cnt_reg == CW'(DEPTH));
    assign empty  = (cnt_reg == '0);
    assign idx_w  = CMPW'(item.index);
    assign cnt_w  = CMPW'(cnt_reg);
    assign idx_ok = (idx_w < cnt_w);

    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign head_inc = wrap_add(head_reg, CW'(1));

    always_comb begin
        case (item.operation)
            OP_PUSH_BACK:   offset = cnt_reg;
            OP_POP_BACK:    offset = cnt_reg - CW'(1);
            OP_READ_INDEX,
            OP_WRITE_INDEX: offset = CW'(idx_w);
            default:        offset = '0;
        endcase
    end

    assign slot      = wrap_add(head_reg, offset);
    assign value_ext = 64'(item.value);
    assign mem_wdata = value_ext[WORD_BITS-1:0];

    always_comb begin
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = slot;
        head_next   = head_reg;
        cnt_next    = cnt_reg;
        meta.rd     = 1'b0;
        meta.status = ST_OK;
        case (item.operation)
            OP_PUSH_BACK: begin
                if (full) begin
                    meta.status = ST_FULL;
                end else begin
                    mem_we   = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            OP_PUSH_FRONT: begin
                mem_addr = head_dec;
                if (full) begin
                    meta.status = ST_FULL;
                end else begin
                    mem_we    = 1'b1;
                    head_next = head_dec;
                    cnt_next  = cnt_reg + CW'(1);
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    meta.status = ST_EMPTY;
                end else begin
                    mem_re   = 1'b1;
                    meta.rd  = 1'b1;
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    meta.status = ST_EMPTY;
                end else begin
                    mem_re    = 1'b1;
                    meta.rd   = 1'b1;
                    head_next = head_inc;
                    cnt_next  = cnt_reg - CW'(1);
                end
            end
            OP_READ_INDEX: begin
                if (!idx_ok) begin
                    meta.status = ST_RANGE;
                end else begin
                    mem_re  = 1'b1;
                    meta.rd = 1'b1;
                end
            end
            OP_WRITE_INDEX: begin
                if (!idx_ok) begin
                    meta.status = ST_RANGE;
                end else begin
                    mem_we = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (!step) begin
            mem_we = 1'b0;
            mem_re = 1'b0;
        end
        meta.count = 8'(cnt_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            cnt_reg  <= '0;
        end else if (step) begin
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

>>> src/indexed_deque_buffer_unit.sv
`timescale 1ns / 1ps
// Indexed deque buffer: a double-ended queue of signed words in a ring memory.
// Depends on idq_pkg, idq_ctrl and idq_ram.
//
// Usage:
// The s_ channel takes one operation word (operation, value, index); the m_
// channel returns exactly one result word per operation (data, count,
// status), in order. Pushes and index writes return data 0; a push to a full
// queue, a pop from an empty one and an index at or beyond the count are
// flagged in status and change nothing.
// Pipeline: the memory read and the pipeline register load at the accepting
// edge, then the result register loads from them once it is free, and
// m_valid is driven from the result register.
// Throughput is one operation per cycle while results are taken; the
// memory ports share one address, and head and count load every accepted cycle.
// Reset empties the queue (head and count cleared) at once; no clearing
// pass is needed, as the entries are only read after they were written.
// When the receiver stalls, the result register holds; one more word may
// enter behind it, and then s_ready drops until the result register is taken.

module indexed_deque_buffer_unit #(
    parameter int DEPTH     = idq_pkg::DEPTH_DEFAULT,
    parameter int WORD_BITS = idq_pkg::WORD_BITS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  idq_pkg::idq_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output idq_pkg::idq_out_t m_data
);
    import idq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic                 step;
    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_addr;
    logic [WORD_BITS-1:0] mem_wdata, mem_rdata;
    idq_meta_t            meta;

    logic                 p_valid_reg;
    idq_meta_t            p_meta_reg;
    logic                 o_valid_reg;
    idq_out_t             o_word_reg, o_word_next;
    logic                 p_advance;
    logic signed [63:0]   rdata_ext;

    assign p_advance = !o_valid_reg || m_ready;
    assign s_ready   = !p_valid_reg || p_advance;
    assign step      = s_valid && s_ready;

    idq_ctrl #(
        .DEPTH    (DEPTH),
        .WORD_BITS(WORD_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .item     (s_data),
        .mem_we   (mem_we),
        .mem_re   (mem_re),
        .mem_addr (mem_addr),
        .mem_wdata(mem_wdata),
        .meta     (meta)
    );

    idq_ram #(
        .DEPTH    (DEPTH),
        .WORD_BITS(WORD_BITS)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_addr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_addr),
        .rdata (mem_rdata)
    );

    // Stored words are sign-extended from WORD_BITS before landing in data.
    assign rdata_ext = 64'(signed'(mem_rdata));

    always_comb begin
        o_word_next.data   = p_meta_reg.rd ? rdata_ext[31:0] : 32'sd0;
        o_word_next.count  = p_meta_reg.count;
        o_word_next.status = p_meta_reg.status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                p_valid_reg <= s_valid;
            end
            if (p_advance) begin
                o_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            p_meta_reg <= meta;
        end
        if (p_advance && p_valid_reg) begin
            o_word_reg <= o_word_next;
        end
    end

    assign m_valid = o_valid_reg;
    assign m_data  = o_word_reg;

endmodule
